// File: rtl/iftg_pkg.sv
// Shared types and constants of the flick and tilt gesture detector.
`default_nettype none
package iftg_pkg;

	localparam int unsigned CFG_W        = 24;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned DIV_STEPS    = 7;
	localparam int unsigned DIV_CNT_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FLICK_THR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLICK_COOL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_HYS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_HOLD  = 3'd4;

	localparam logic [14:0] FLICK_THR_RST  = 15'd25600;
	localparam logic [23:0] FLICK_COOL_RST = 24'd500000;
	localparam logic [12:0] TILT_THR_RST   = 13'd1920;
	localparam logic [12:0] TILT_HYS_RST   = 13'd960;
	localparam logic [23:0] TILT_HOLD_RST  = 24'd500000;

	// 90 degrees in 1/64 degree
	localparam logic signed [15:0] RIGHT_ANGLE = 16'sd5760;

	localparam logic [1:0] GEST_FLICK = 2'd0;
	localparam logic [1:0] GEST_LEFT  = 2'd1;
	localparam logic [1:0] GEST_RIGHT = 2'd2;

	localparam logic [8:0] CONF_HALF = 9'd128;
	localparam logic [8:0] CONF_FULL = 9'd256;

	typedef enum logic [2:0] {
		TP_IDLE    = 3'd0,
		TP_ARMED_R = 3'd1,
		TP_ARMED_L = 3'd2,
		TP_FIRED_R = 3'd3,
		TP_FIRED_L = 3'd4
	} tilt_phase_t;

	typedef enum logic [1:0] {
		CK_HALF   = 2'd0,
		CK_FULL   = 2'd1,
		CK_DIVIDE = 2'd2
	} conf_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_DIV  = 2'd1,
		BK_DONE = 2'd2
	} bk_state_t;

	// One pending event: the division operands satisfy excess < den when kind is divide
	typedef struct packed {
		logic [1:0]  gesture;
		logic        last;
		conf_kind_t  kind;
		logic [14:0] excess;
		logic [14:0] den;
	} cq_entry_t;

	typedef struct packed {
		logic [1:0] num;
		cq_entry_t  first;
		cq_entry_t  second;
	} cq_push_t;

endpackage
`default_nettype wire

// File: rtl/iftg_front.sv
// Front end: register file, flick cooldown and tilt state machine, event classification.
`default_nettype none
module iftg_front import iftg_pkg::*; #(
	parameter int TIME_WIDTH = 48
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic signed [15:0]    gyro_z,
	input  wire logic signed [14:0]    roll,
	input  wire logic [TIME_WIDTH-1:0] sample_time_us,
	input  wire logic                  room2,
	output cq_push_t                   push
);

	logic [14:0]           flick_thr_q;
	logic [23:0]           flick_cool_q;
	logic [12:0]           tilt_thr_q;
	logic [12:0]           tilt_hys_q;
	logic [23:0]           tilt_hold_q;
	logic [TIME_WIDTH-1:0] last_flick_time_q;
	logic [TIME_WIDTH-1:0] tilt_arm_time_q;
	tilt_phase_t           tilt_phase_q;

	logic                  accept;
	logic                  cool_ok;
	logic                  hold_ok;
	logic [15:0]           mag;
	logic                  flick_fire;
	logic signed [15:0]    roll16;
	logic signed [15:0]    thr16;
	logic signed [15:0]    hys16;
	logic signed [16:0]    exc_right;
	logic signed [16:0]    exc_left;
	logic signed [16:0]    flick_exc;
	logic signed [15:0]    tilt_den;
	tilt_phase_t           phase_d;
	logic                  arm;
	logic                  tilt_fire;
	logic [1:0]            tilt_gest;
	cq_entry_t             flick_ent;
	cq_entry_t             tilt_ent;

	function automatic cq_entry_t classify(input logic [1:0] gest,
			input logic signed [16:0] exc, input logic signed [15:0] den);
		cq_entry_t e;
		e.gesture = gest;
		e.last    = 1'b1;
		e.excess  = exc[14:0];
		e.den     = den[14:0];
		if (exc <= 17'sd0 || den < 16'sd0) begin
			e.kind = CK_HALF;
		end else if (den == 16'sd0) begin
			e.kind = CK_FULL;
		end else if (exc >= {den[15], den}) begin
			e.kind = CK_FULL;
		end else begin
			e.kind = CK_DIVIDE;
		end
		return e;
	endfunction

	assign in_stall = !room2;
	assign accept   = in_valid && !in_stall;

	// elapsed time counts as zero when the clock appears to run backwards
	always_comb begin
		if (sample_time_us >= last_flick_time_q) begin
			cool_ok = (sample_time_us - last_flick_time_q) >=
				{{(TIME_WIDTH-24){1'b0}}, flick_cool_q};
		end else begin
			cool_ok = (flick_cool_q == 24'd0);
		end
		if (sample_time_us >= tilt_arm_time_q) begin
			hold_ok = (sample_time_us - tilt_arm_time_q) >=
				{{(TIME_WIDTH-24){1'b0}}, tilt_hold_q};
		end else begin
			hold_ok = (tilt_hold_q == 24'd0);
		end
	end

	assign mag        = gyro_z[15] ? (16'd0 - gyro_z) : gyro_z;
	assign flick_fire = cool_ok && (mag > {1'b0, flick_thr_q});
	assign flick_exc  = signed'({1'b0, mag - {1'b0, flick_thr_q}});

	assign roll16    = {roll[14], roll};
	assign thr16     = signed'({3'b000, tilt_thr_q});
	assign hys16     = signed'({3'b000, tilt_hys_q});
	assign exc_right = {roll16[15], roll16} - {thr16[15], thr16};
	assign exc_left  = 17'sd0 - {roll16[15], roll16} - {thr16[15], thr16};
	assign tilt_den  = RIGHT_ANGLE - thr16;

	always_comb begin
		phase_d   = tilt_phase_q;
		arm       = 1'b0;
		tilt_fire = 1'b0;
		tilt_gest = GEST_RIGHT;
		case (tilt_phase_q)
			TP_ARMED_R: begin
				if (roll16 < (16'sd0 - hys16)) begin
					phase_d = TP_ARMED_L;
					arm     = 1'b1;
				end else if (roll16 < hys16) begin
					phase_d = TP_IDLE;
				end else if (hold_ok) begin
					phase_d   = TP_FIRED_R;
					tilt_fire = 1'b1;
				end
			end
			TP_ARMED_L: begin
				tilt_gest = GEST_LEFT;
				if (roll16 > thr16) begin
					phase_d = TP_ARMED_R;
					arm     = 1'b1;
				end else if (roll16 > (16'sd0 - hys16)) begin
					phase_d = TP_IDLE;
				end else if (hold_ok) begin
					phase_d   = TP_FIRED_L;
					tilt_fire = 1'b1;
				end
			end
			TP_FIRED_R: begin
				if (roll16 < hys16) phase_d = TP_IDLE;
			end
			TP_FIRED_L: begin
				if (roll16 > (16'sd0 - hys16)) phase_d = TP_IDLE;
			end
			default: begin
				if (roll16 > thr16) begin
					phase_d = TP_ARMED_R;
					arm     = 1'b1;
				end else if (roll16 < (16'sd0 - thr16)) begin
					phase_d = TP_ARMED_L;
					arm     = 1'b1;
				end else begin
					phase_d = TP_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		flick_ent = classify(GEST_FLICK, flick_exc, signed'({1'b0, flick_thr_q}));
		tilt_ent  = classify(tilt_gest,
			(tilt_gest == GEST_LEFT) ? exc_left : exc_right, tilt_den);
		flick_ent.last = !tilt_fire;
		push.num    = accept ? ({1'b0, flick_fire} + {1'b0, tilt_fire}) : 2'd0;
		push.first  = flick_fire ? flick_ent : tilt_ent;
		push.second = tilt_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flick_thr_q  <= FLICK_THR_RST;
			flick_cool_q <= FLICK_COOL_RST;
			tilt_thr_q   <= TILT_THR_RST;
			tilt_hys_q   <= TILT_HYS_RST;
			tilt_hold_q  <= TILT_HOLD_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FLICK_THR:  flick_thr_q  <= cfg_data[14:0];
				REG_FLICK_COOL: flick_cool_q <= cfg_data;
				REG_TILT_THR:   tilt_thr_q   <= cfg_data[12:0];
				REG_TILT_HYS:   tilt_hys_q   <= cfg_data[12:0];
				REG_TILT_HOLD:  tilt_hold_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_flick_time_q <= '0;
			tilt_arm_time_q   <= '0;
			tilt_phase_q      <= TP_IDLE;
		end else if (accept) begin
			if (flick_fire) last_flick_time_q <= sample_time_us;
			if (arm) tilt_arm_time_q <= sample_time_us;
			tilt_phase_q <= phase_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/iftg_queue.sv
// Short event queue between front and back end, two writes and one read a cycle.
`default_nettype none
module iftg_queue import iftg_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cq_push_t push,
	input  wire logic     pop,
	output cq_entry_t     head,
	output logic          nonempty,
	output logic          room2
);

	cq_entry_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head     = mem_q[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign room2    = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) mem_q[wr_ptr_q] <= push.first;
		if (push.num == 2'd2) mem_q[wr_ptr_q + 1'b1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.num);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + QCNT_W'(push.num) - QCNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("event queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from empty event queue");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num != 2'd0) |-> room2)
		else $error("push into event queue without room");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(QPTR_W'(count_q) == (wr_ptr_q - rd_ptr_q)))
		else $error("event queue pointers disagree with count");

endmodule
`default_nettype wire

// File: rtl/iftg_back.sv
// Back end: restoring divider for the confidence and the output register.
`default_nettype none
module iftg_back import iftg_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cq_entry_t head,
	input  wire logic      nonempty,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_stall,
	output logic [1:0]     gesture,
	output logic [8:0]     confidence,
	output logic           last
);

	bk_state_t            state_q;
	bk_state_t            state_d;
	logic [DIV_CNT_W-1:0] step_q;
	logic [14:0]          rem_q;
	logic [14:0]          den_q;
	logic [6:0]           quot_q;
	logic [1:0]           gest_q;
	logic                 last_q;
	logic [8:0]           conf_q;
	logic                 out_valid_q;
	logic [1:0]           out_gest_q;
	logic [8:0]           out_conf_q;
	logic                 out_last_q;

	logic                 out_free;
	logic                 load_out;
	logic                 last_step;
	logic [15:0]          rem2;
	logic                 ge;
	logic [14:0]          rem_next;
	logic [6:0]           quot_next;

	assign out_free  = !out_valid_q || !out_stall;
	assign last_step = (step_q == DIV_CNT_W'(DIV_STEPS - 1));

	// one quotient bit a cycle; remainder stays below the divisor
	assign rem2      = {rem_q, 1'b0};
	assign ge        = rem2 >= {1'b0, den_q};
	assign rem_next  = ge ? 15'(rem2 - {1'b0, den_q}) : rem2[14:0];
	assign quot_next = {quot_q[5:0], ge};

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (nonempty) state_d = (head.kind == CK_DIVIDE) ? BK_DIV : BK_DONE;
			end
			BK_DIV: begin
				if (last_step) state_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == BK_IDLE) && nonempty;
		load_out = (state_q == BK_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			gest_q <= head.gesture;
			last_q <= head.last;
			rem_q  <= head.excess;
			den_q  <= head.den;
			quot_q <= '0;
			step_q <= '0;
			conf_q <= (head.kind == CK_FULL) ? CONF_FULL : CONF_HALF;
		end else if (state_q == BK_DIV) begin
			rem_q  <= rem_next;
			quot_q <= quot_next;
			step_q <= step_q + 1'b1;
			if (last_step) conf_q <= {2'b01, quot_next};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_gest_q <= gest_q;
			out_conf_q <= conf_q;
			out_last_q <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign gesture    = out_gest_q;
	assign confidence = out_conf_q;
	assign last       = out_last_q;

endmodule
`default_nettype wire

// File: rtl/imu_flick_tilt_gesture_detect.sv
// Flick and tilt gesture detector for IMU samples.
//
// Input channel: in_valid/in_stall with gyro_z, roll (1/64 degree) and
// sample_time_us. Each accepted sample updates the flick cooldown and the tilt
// state machine at once and may raise up to two events, flick first.
// Output channel: out_valid/out_stall with gesture, confidence (1/256 units)
// and last, set on the final event of a sample.
// Events go into a four-entry queue; the back end takes one at a time and
// runs a seven-step restoring divider for the confidence. A clamped event
// goes from idle straight to done, a divided one through the divider
// steps first; done then loads the output register, which raises out_valid.
// The divider sets the rate; new samples can still be taken while earlier
// events wait in the queue or in the divider. The front end takes a sample
// a cycle while the queue has room for two events and raises in_stall
// otherwise. A stalled result holds in the output register while the back
// end finishes the next event. Reset clears the registers to their
// defaults, the tilt machine to idle and both stored times to zero. The user
// must write the configuration port only while idle; the block itself does
// not enforce it.
`default_nettype none
module imu_flick_tilt_gesture_detect import iftg_pkg::*; #(
	parameter int TIME_WIDTH = 48
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic signed [15:0]    gyro_z,
	input  wire logic signed [14:0]    roll,
	input  wire logic [TIME_WIDTH-1:0] sample_time_us,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 gesture,
	output logic [8:0]                 confidence,
	output logic                       last
);

	cq_push_t  push;
	cq_entry_t head;
	logic      pop;
	logic      nonempty;
	logic      room2;

	iftg_front #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.gyro_z         (gyro_z),
		.roll           (roll),
		.sample_time_us (sample_time_us),
		.room2          (room2),
		.push           (push)
	);

	iftg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.head     (head),
		.nonempty (nonempty),
		.room2    (room2)
	);

	iftg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.nonempty   (nonempty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.gesture    (gesture),
		.confidence (confidence),
		.last       (last)
	);

endmodule
`default_nettype wire

// File: test/tb_imu_flick_tilt_gesture_detect.sv
// Testbench for the flick and tilt gesture detector: directed edge cases and random IMU traffic.
`timescale 1ns / 100ps

module tb_imu_flick_tilt_gesture_detect import iftg_pkg::*;;

	localparam int TIME_W        = 48;
	localparam int SETTLE_CYCLES = 30;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int ROLL_MAX      = 11520;

	typedef struct {
		logic [1:0]  gesture;
		logic [8:0]  confidence;
		logic        last;
		int unsigned sample_no;
	} expected_event_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic signed [15:0] gyro_z;
	logic signed [14:0] roll;
	logic [TIME_W-1:0] sample_time_us;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        gesture;
	logic [8:0]        confidence;
	logic              last;

	// copy of the detector's registers and state
	logic [14:0]       flick_thr_r;
	logic [23:0]       flick_cool_r;
	logic [12:0]       tilt_thr_r;
	logic [12:0]       tilt_hys_r;
	logic [23:0]       tilt_hold_r;
	logic [TIME_W-1:0] flick_at;
	logic [TIME_W-1:0] armed_at;
	tilt_phase_t       phase_q;

	expected_event_t   expected_events[$];
	int unsigned       samples_sent;
	int unsigned       mismatches;
	int unsigned       cycle_count;
	logic [TIME_W-1:0] now_us;
	int                idle_odds;
	bit                calm;

	imu_flick_tilt_gesture_detect #(
		.TIME_WIDTH(TIME_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.gyro_z(gyro_z),
		.roll(roll),
		.sample_time_us(sample_time_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gesture(gesture),
		.confidence(confidence),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [TIME_W-1:0] span_since(logic [TIME_W-1:0] now, logic [TIME_W-1:0] mark);
		return (now >= mark) ? now - mark : '0;
	endfunction

	function automatic logic [8:0] grade_confidence(longint excess, longint den);
		longint q;
		if (excess <= 0 || den < 0) return CONF_HALF;
		if (den == 0) return CONF_FULL;
		q = (excess * 128) / den;
		if (q >= 128) return CONF_FULL;
		return 9'(128 + q);
	endfunction

	// Work out the events one accepted request raises, flick first.
	function automatic void track_sample(logic signed [15:0] g, logic signed [14:0] r,
			logic [TIME_W-1:0] now);
		expected_event_t found[2];
		int n;
		int mag;
		int thr;
		int hys;
		int rl;
		int den;
		n = 0;
		thr = int'(tilt_thr_r);
		hys = int'(tilt_hys_r);
		rl = int'(r);
		den = int'(RIGHT_ANGLE) - thr;
		if (span_since(now, flick_at) >= TIME_W'(flick_cool_r)) begin
			mag = (g < 0) ? -int'(g) : int'(g);
			if (mag > int'(flick_thr_r)) begin
				found[n].gesture = GEST_FLICK;
				found[n].confidence = grade_confidence(mag - int'(flick_thr_r), int'(flick_thr_r));
				n++;
				flick_at = now;
			end
		end
		case (phase_q)
			TP_ARMED_R: begin
				if (rl < -hys) begin
					phase_q = TP_ARMED_L;
					armed_at = now;
				end else if (rl < hys) begin
					phase_q = TP_IDLE;
				end else if (span_since(now, armed_at) >= TIME_W'(tilt_hold_r)) begin
					found[n].gesture = GEST_RIGHT;
					found[n].confidence = grade_confidence(rl - thr, den);
					n++;
					phase_q = TP_FIRED_R;
				end
			end
			TP_ARMED_L: begin
				if (rl > thr) begin
					phase_q = TP_ARMED_R;
					armed_at = now;
				end else if (rl > -hys) begin
					phase_q = TP_IDLE;
				end else if (span_since(now, armed_at) >= TIME_W'(tilt_hold_r)) begin
					found[n].gesture = GEST_LEFT;
					found[n].confidence = grade_confidence(-rl - thr, den);
					n++;
					phase_q = TP_FIRED_L;
				end
			end
			TP_FIRED_R: begin
				if (rl < hys) phase_q = TP_IDLE;
			end
			TP_FIRED_L: begin
				if (rl > -hys) phase_q = TP_IDLE;
			end
			default: begin
				if (rl > thr) begin
					phase_q = TP_ARMED_R;
					armed_at = now;
				end else if (rl < -thr) begin
					phase_q = TP_ARMED_L;
					armed_at = now;
				end else begin
					phase_q = TP_IDLE;
				end
			end
		endcase
		for (int k = 0; k < n; k++) begin
			found[k].last = (k == n - 1);
			found[k].sample_no = samples_sent;
			expected_events.push_back(found[k]);
		end
	endfunction

	task automatic note_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_FLICK_THR:  flick_thr_r = data[14:0];
			REG_FLICK_COOL: flick_cool_r = data[23:0];
			REG_TILT_THR:   tilt_thr_r = data[12:0];
			REG_TILT_HYS:   tilt_hys_r = data[12:0];
			REG_TILT_HOLD:  tilt_hold_r = data[23:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic offer_sample(input int g, input int r, input logic [TIME_W-1:0] t);
		int gap;
		gap = 0;
		if (!calm && idle_odds != 0 && $urandom_range(1, 8) <= idle_odds)
			gap = $urandom_range(1, 11);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		gyro_z <= 16'(g);
		roll <= 15'(r);
		sample_time_us <= t;
		// hold the request until taken
		do @(posedge clk); while (in_stall);
		track_sample(16'(g), 15'(r), t);
		samples_sent++;
	endtask

	// Drop valid and let every expected event drain, then allow the back end to go idle.
	task automatic wait_quiet;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_gyro();
		int mag;
		case ($urandom_range(0, 9))
			0, 1, 2: mag = int'($urandom_range(0, flick_thr_r));
			3, 4, 5: mag = int'(flick_thr_r) + int'($urandom_range(1, 2000));
			6:       mag = int'(flick_thr_r);
			7:       return $urandom_range(0, 1) ? 32767 : -32768;
			default: return int'($signed(16'($urandom)));
		endcase
		if (mag > 32767) mag = 32767;
		return $urandom_range(0, 1) ? mag : -mag;
	endfunction

	function automatic int pick_roll_level();
		int thr;
		int hys;
		int lvl;
		thr = int'(tilt_thr_r);
		hys = int'(tilt_hys_r);
		case ($urandom_range(0, 9))
			0, 1: lvl = thr + int'($urandom_range(1, 3000));
			2, 3: lvl = -(thr + int'($urandom_range(1, 3000)));
			4:    lvl = thr + int'($urandom_range(0, 1));
			5:    lvl = hys - int'($urandom_range(0, 1));
			6:    lvl = int'($urandom_range(0, hys));
			7:    lvl = ROLL_MAX;
			default: lvl = int'($urandom_range(0, 2 * ROLL_MAX)) - ROLL_MAX;
		endcase
		if (lvl >= 4 && lvl <= 7 && $urandom_range(0, 1)) lvl = -lvl;
		if ($urandom_range(0, 1) && (lvl == ROLL_MAX)) lvl = -ROLL_MAX;
		if (lvl > ROLL_MAX) lvl = ROLL_MAX;
		if (lvl < -ROLL_MAX) lvl = -ROLL_MAX;
		return lvl;
	endfunction

	// Load one setting of all five registers; junk in the upper bits must be masked off.
	task automatic load_settings(input int phase);
		int fthr;
		int cool;
		int tthr;
		int hys;
		int hold;
		case (phase)
			0: begin
				fthr = 1; cool = 0; tthr = 1; hys = 0; hold = 0;
			end
			1: begin
				fthr = 32767; cool = 24'hFFFFFF; tthr = 5759; hys = 5759; hold = 24'hFFFFFF;
			end
			default: begin
				fthr = $urandom_range(0, 1) ? int'($urandom_range(1, 32767))
					: int'($urandom_range(1, 3000));
				cool = $urandom_range(0, 4000);
				tthr = (phase == 2) ? int'($urandom_range(5760, 8191))
					: int'($urandom_range(1, 5759));
				hys = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 8191))
					: int'($urandom_range(0, tthr));
				hold = $urandom_range(0, 4000);
			end
		endcase
		write_register(REG_FLICK_THR, {9'($urandom), 15'(fthr)});
		write_register(REG_FLICK_COOL, 24'(cool));
		write_register(REG_TILT_THR, {11'($urandom), 13'(tthr)});
		write_register(REG_TILT_HYS, {11'($urandom), 13'(hys)});
		write_register(REG_TILT_HOLD, 24'(hold));
	endtask

	task automatic test_default_settings;
		idle_odds = 2;
		offer_sample(32767, 0, 0);                 // cooldown counts from time zero
		offer_sample(25600, 0, 500000);            // at threshold: not exceeded
		offer_sample(-32768, 0, 500000);
		offer_sample(32767, 1921, 700000);         // still in cooldown, arm right
		offer_sample(0, 1920, 1200000);            // hold met, zero excess
		offer_sample(0, 959, 1300000);
		offer_sample(32767, -11520, 1500000);
		offer_sample(32767, -11520, 2000000);      // flick and tilt left together
		offer_sample(32767, -5000, 1900000);       // time runs backward
		offer_sample(0, 0, 2100000);
		offer_sample(0, 3000, 2200000);
		offer_sample(0, -961, 2300000);            // swap to left through hysteresis
		offer_sample(0, 2000, 2400000);            // swap back to right
		offer_sample(0, 959, 2400000);
	endtask

	task automatic test_register_edges;
		logic [TIME_W-1:0] t0;
		int i;
		wait_quiet();
		for (i = int'(REG_TILT_HOLD) + 1; i < (1 << CFG_IDX_W); i++)
			write_register(CFG_IDX_W'(i), CFG_W'($urandom));
		// zero flick threshold, tilt threshold beyond 90 degrees
		write_register(REG_FLICK_THR, 24'h008000);
		write_register(REG_FLICK_COOL, '0);
		write_register(REG_TILT_THR, 24'hFFFFFF);
		write_register(REG_TILT_HYS, 24'h002000);
		write_register(REG_TILT_HOLD, '0);
		offer_sample(0, 0, 3000000);
		offer_sample(1, 8192, 3000001);
		offer_sample(-1, 11520, 3000001);
		offer_sample(0, -1, 3000002);
		wait_quiet();
		// threshold at exactly 90 degrees
		write_register(REG_TILT_THR, 24'(int'(RIGHT_ANGLE)));
		offer_sample(0, -5761, 3000003);
		offer_sample(0, -5761, 3000003);
		offer_sample(0, 1, 3000004);
		offer_sample(32767, 0, '1);
		offer_sample(-32768, 0, 3000010);
		wait_quiet();
		write_register(REG_FLICK_THR, 24'd32767);
		write_register(REG_FLICK_COOL, 24'hFFFFFF);
		write_register(REG_TILT_THR, 24'd1);
		write_register(REG_TILT_HYS, 24'd5759);
		write_register(REG_TILT_HOLD, 24'hFFFFFF);
		t0 = 48'd3000010 + 48'd16777214;
		offer_sample(-32768, 11520, t0);
		offer_sample(-32768, 11520, t0 + 48'd16777215);
		offer_sample(0, 5758, t0 + 48'd16777216);
		now_us = t0 + 48'd16777216;
	endtask

	task automatic test_random_traffic;
		int phase;
		int i;
		int level;
		int run_left;
		int r;
		int span;
		int back;
		for (phase = 0; phase < 9; phase++) begin
			wait_quiet();
			if (phase >= 8) calm = 1'b1;
			load_settings(phase);
			idle_odds = calm ? 0 : int'($urandom_range(0, 4));
			span = ((tilt_hold_r > flick_cool_r) ? int'(tilt_hold_r) : int'(flick_cool_r)) / 2 + 1;
			now_us = now_us + 48'($urandom_range(1, 1000000));
			run_left = 0;
			level = 0;
			for (i = 0; i < 50; i++) begin
				if (run_left == 0) begin
					level = pick_roll_level();
					run_left = $urandom_range(1, 6);
				end
				run_left--;
				r = ($urandom_range(0, 9) == 0)
					? int'($urandom_range(0, 2 * ROLL_MAX)) - ROLL_MAX : level;
				case ($urandom_range(0, 49))
					0, 1: begin
						back = $urandom_range(0, span);
						if (now_us >= 48'(back)) now_us = now_us - 48'(back);
					end
					2:       now_us = now_us + 48'($urandom);
					default: now_us = now_us + 48'($urandom_range(0, span));
				endcase
				offer_sample(pick_gyro(), r, now_us);
				// hold off once until the detector has drained
				if (phase == 3 && i == 25) wait_quiet();
			end
		end
	endtask

	always begin
		@(negedge clk);
		if (!calm && arst_n && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 11)) @(negedge clk);
			out_stall <= 1'b0;
			if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 80)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		expected_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_events.size() == 0) begin
				note_mismatch($sformatf("unexpected event: gesture %0d confidence %0d last %0b",
					gesture, confidence, last));
			end else begin
				want = expected_events.pop_front();
				if (gesture !== want.gesture)
					note_mismatch($sformatf("sample %0d: gesture %0d, want %0d",
						want.sample_no, gesture, want.gesture));
				if (confidence !== want.confidence)
					note_mismatch($sformatf("sample %0d: confidence %0d, want %0d",
						want.sample_no, confidence, want.confidence));
				if (last !== want.last)
					note_mismatch($sformatf("sample %0d: last %0b, want %0b",
						want.sample_no, last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_imu_flick_tilt_gesture_detect: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		gyro_z = '0;
		roll = '0;
		sample_time_us = '0;
		out_stall = 1'b0;
		flick_thr_r = FLICK_THR_RST;
		flick_cool_r = FLICK_COOL_RST;
		tilt_thr_r = TILT_THR_RST;
		tilt_hys_r = TILT_HYS_RST;
		tilt_hold_r = TILT_HOLD_RST;
		flick_at = '0;
		armed_at = '0;
		phase_q = TP_IDLE;
		samples_sent = 0;
		mismatches = 0;
		cycle_count = 0;
		now_us = '0;
		idle_odds = 0;
		calm = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_default_settings();
		test_register_edges();
		test_random_traffic();
		wait_quiet();

		if (mismatches == 0) begin
			$display("tb_imu_flick_tilt_gesture_detect: clean");
		end else begin
			$display("tb_imu_flick_tilt_gesture_detect: errors");
		end
		$finish;
	end

endmodule
